FILE: design/five_stage_pipeline_core_defines.svh
// Assertion macros for the five-stage pipeline core.
// Included by design/five_stage_pipeline_core.sv; no other dependencies.
`ifndef FIVE_STAGE_PIPELINE_CORE_DEFINES_SVH
`define FIVE_STAGE_PIPELINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FSPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fspc assertion failed");
// next-cycle implication
`define FSPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fspc assertion failed");
`else
`define FSPC_ASSERT_NOW(label, clk, rst, ante, cons)
`define FSPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/fspc_pkg.sv
// Shared types and constants of the five-stage pipeline core.
// No dependencies; used by the core, its checker and its testbench.
package fspc_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_READ  = 2'd2
   } command_type;

   // opcodes
   localparam logic [3:0] OP_RTYPE = 4'd0;
   localparam logic [3:0] OP_JUMP  = 4'd2;
   localparam logic [3:0] OP_ADDI  = 4'd4;
   localparam logic [3:0] OP_LW    = 4'd11;
   localparam logic [3:0] OP_SW    = 4'd15;

   // R-type function codes
   localparam logic [2:0] FN_ADD = 3'd0;
   localparam logic [2:0] FN_SUB = 3'd2;
   localparam logic [2:0] FN_AND = 3'd4;
   localparam logic [2:0] FN_OR  = 3'd5;

   localparam int REG_COUNT = 8;
   localparam int REG_IDX_W = 3;
   localparam int IMM_W     = 6;
   localparam int PC_W      = 9;
   localparam int ADDR_W    = 8;

endpackage

FILE: design/five_stage_pipeline_core.sv
// Five-stage in-order pipeline core (16-bit ports, eight registers, no hazard logic).
// Depends on fspc_pkg and five_stage_pipeline_core_defines.svh.
//
//   port group | direction | handshake       | content
//   req_*      | in        | valid / stall   | command, instruction word, address, data
//   rsp_*      | out       | valid / stall   | writeback, store, read data, pc, halt
//   csr_*      | in        | write enable    | program length
//
// One transaction per clock while req_stall is low: each item updates the state it
// touches at its accept edge, where its result is also captured in the output register.
// The output register stalls the input only while a result is held by rsp_stall.
// Data memory and register file reads are registered reads.
// Reset is synchronous; the register file and data memory read as zero until written.
`include "five_stage_pipeline_core_defines.svh"

module five_stage_pipeline_core #(
   parameter int DATA_WORDS = 256,
   parameter int WORD_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [fspc_pkg::PC_W-1:0]            csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_command,
   input  logic [15:0]                          req_instr_word,
   input  logic [fspc_pkg::ADDR_W-1:0]          req_address,
   input  logic [15:0]                          req_write_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_reg_write,
   output logic [fspc_pkg::REG_IDX_W-1:0]       rsp_reg_index,
   output logic [15:0]                          rsp_reg_value,
   output logic                                 rsp_mem_write,
   output logic [fspc_pkg::ADDR_W-1:0]          rsp_mem_address,
   output logic [15:0]                          rsp_mem_value,
   output logic [15:0]                          rsp_read_data,
   output logic [fspc_pkg::PC_W-1:0]            rsp_pc_value,
   output logic                                 rsp_halted
);

   localparam int IDX_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
   localparam int ADDR_SPAN = 1 << fspc_pkg::ADDR_W;

   // fold an 8-bit address onto the data memory depth
   function automatic logic [ADDR_SPAN-1:0][IDX_W-1:0] build_wrap();
      logic [ADDR_SPAN-1:0][IDX_W-1:0] t;
      for (int i = 0; i < ADDR_SPAN; i++) begin
         t[i] = IDX_W'(i % DATA_WORDS);
      end
      return t;
   endfunction

   localparam logic [ADDR_SPAN-1:0][IDX_W-1:0] WRAP_TABLE = build_wrap();

   function automatic logic [15:0] lo16(input logic [WORD_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[15:0];
   endfunction

   function automatic logic [fspc_pkg::ADDR_W-1:0] lo8(input logic [WORD_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[fspc_pkg::ADDR_W-1:0];
   endfunction

   // ---------------------------------------------------------------- state
   logic [fspc_pkg::PC_W-1:0]      plen_ff;
   logic [fspc_pkg::PC_W-1:0]      pc_ff, pc_in;
   logic                           halt_ff, halt_in;

   logic [WORD_BITS-1:0]           rf_mem_ff [fspc_pkg::REG_COUNT];
   logic [fspc_pkg::REG_COUNT-1:0] rf_vld_ff;
   logic [WORD_BITS-1:0]           data_mem_ff [DATA_WORDS];
   logic [DATA_WORDS-1:0]          data_vld_ff;

   logic [15:0]                    fetch_ff;

   logic [3:0]                     dec_op_ff;
   logic [fspc_pkg::REG_IDX_W-1:0] dec_rt_ff, dec_rd_ff;
   logic [2:0]                     dec_funct_ff;
   logic [fspc_pkg::IMM_W-1:0]     dec_imm_ff;
   logic [WORD_BITS-1:0]           dec_a_ff, dec_b_ff;

   logic [3:0]                     ex_op_ff;
   logic [WORD_BITS-1:0]           ex_alu_ff, ex_alu_in, ex_b_ff;
   logic [fspc_pkg::REG_IDX_W-1:0] ex_wreg_ff, ex_wreg_in;
   logic                           ex_upd, ex_b_upd;

   logic [3:0]                     mem_op_ff;
   logic [WORD_BITS-1:0]           mem_alu_ff, mem_mdata_ff;
   logic [fspc_pkg::REG_IDX_W-1:0] mem_wreg_ff;

   logic [15:0]                    rd_data_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_reg_write_ff;
   logic [fspc_pkg::REG_IDX_W-1:0] rsp_reg_index_ff;
   logic [15:0]                    rsp_reg_value_ff;
   logic                           rsp_mem_write_ff;
   logic [fspc_pkg::ADDR_W-1:0]    rsp_mem_address_ff;
   logic [15:0]                    rsp_mem_value_ff;

   // ---------------------------------------------------------------- handshake
   logic accept, run_go, is_write, is_read;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign is_write  = req_command == fspc_pkg::CMD_WRITE;
   assign is_read   = req_command == fspc_pkg::CMD_READ;
   assign run_go    = accept & (req_command == fspc_pkg::CMD_RUN) & ~halt_ff;

   // ---------------------------------------------------------------- writeback
   logic                           wb_en;
   logic [WORD_BITS-1:0]           wb_val;

   assign wb_en  = (mem_op_ff == fspc_pkg::OP_RTYPE) || (mem_op_ff == fspc_pkg::OP_ADDI) ||
                   (mem_op_ff == fspc_pkg::OP_LW);
   assign wb_val = (mem_op_ff == fspc_pkg::OP_LW) ? mem_mdata_ff : mem_alu_ff;

   // ---------------------------------------------------------------- memory stage
   logic                           ms_load, ms_store;
   logic [fspc_pkg::ADDR_W-1:0]    ms_addr;
   logic [IDX_W-1:0]               ms_idx, req_idx, dm_waddr, dm_raddr;
   logic                           dm_we;
   logic [WORD_BITS-1:0]           dm_wdata;

   assign ms_load  = ex_op_ff == fspc_pkg::OP_LW;
   assign ms_store = ex_op_ff == fspc_pkg::OP_SW;
   assign ms_addr  = lo8(ex_alu_ff);
   assign ms_idx   = WRAP_TABLE[ms_addr];
   assign req_idx  = WRAP_TABLE[req_address];

   assign dm_we    = (accept & is_write) | (run_go & ms_store);
   assign dm_waddr = is_write ? req_idx : ms_idx;
   assign dm_wdata = is_write ? WORD_BITS'(req_write_value) : ex_b_ff;
   assign dm_raddr = is_read ? req_idx : ms_idx;

   // ---------------------------------------------------------------- execute stage
   logic [WORD_BITS-1:0] imm_ext;

   assign imm_ext = WORD_BITS'(dec_imm_ff);

   always_comb begin
      ex_alu_in  = ex_alu_ff;
      ex_wreg_in = ex_wreg_ff;
      ex_upd     = 1'b0;
      ex_b_upd   = 1'b0;
      if (dec_op_ff == fspc_pkg::OP_RTYPE) begin
         ex_upd     = 1'b1;
         ex_wreg_in = dec_rd_ff;
         case (dec_funct_ff)
            fspc_pkg::FN_ADD: ex_alu_in = dec_a_ff + dec_b_ff;
            fspc_pkg::FN_SUB: ex_alu_in = dec_a_ff - dec_b_ff;
            fspc_pkg::FN_AND: ex_alu_in = dec_a_ff & dec_b_ff;
            fspc_pkg::FN_OR:  ex_alu_in = dec_a_ff | dec_b_ff;
            default:          ex_alu_in = '0;
         endcase
      end else if (dec_op_ff == fspc_pkg::OP_ADDI) begin
         ex_upd     = 1'b1;
         ex_wreg_in = dec_rt_ff;
         ex_alu_in  = dec_a_ff + imm_ext;
      end else if ((dec_op_ff == fspc_pkg::OP_LW) || (dec_op_ff == fspc_pkg::OP_SW)) begin
         ex_upd     = 1'b1;
         ex_b_upd   = 1'b1;
         ex_wreg_in = dec_rt_ff;
         ex_alu_in  = dec_a_ff + imm_ext;
      end
   end

   // ---------------------------------------------------------------- decode stage
   logic [3:0]                     dc_op;
   logic [fspc_pkg::REG_IDX_W-1:0] dc_rs, dc_rt, dc_rd;
   logic [2:0]                     dc_funct;
   logic [fspc_pkg::IMM_W-1:0]     dc_imm;

   always_comb begin
      dc_op    = fetch_ff[15:12];
      dc_rs    = '0;
      dc_rt    = '0;
      dc_rd    = '0;
      dc_funct = '0;
      dc_imm   = '0;
      if (dc_op == fspc_pkg::OP_RTYPE) begin
         dc_rs    = fetch_ff[11:9];
         dc_rt    = fetch_ff[8:6];
         dc_rd    = fetch_ff[5:3];
         dc_funct = fetch_ff[2:0];
      end else if (dc_op != fspc_pkg::OP_JUMP) begin
         dc_rs  = fetch_ff[11:9];
         dc_rt  = fetch_ff[8:6];
         dc_imm = fetch_ff[5:0];
      end
   end

   // ---------------------------------------------------------------- pc and halt
   logic [fspc_pkg::PC_W-1:0] pc_inc;

   assign pc_inc  = pc_ff + fspc_pkg::PC_W'(1);
   assign pc_in   = run_go ? pc_inc : pc_ff;
   assign halt_in = run_go ? (pc_inc >= plen_ff) : halt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
         pc_ff   <= '0;
         halt_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            plen_ff <= csr_write_data;
         end
         pc_ff   <= pc_in;
         halt_ff <= halt_in;
      end
   end

   // ---------------------------------------------------------------- register file
   always_ff @(posedge clock) begin
      if (run_go && wb_en) begin
         rf_mem_ff[mem_wreg_ff] <= wb_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else if (run_go && wb_en) begin
         rf_vld_ff[mem_wreg_ff] <= 1'b1;
      end
   end

   // decode reads see this cycle's writeback
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_a_ff <= '0;
         dec_b_ff <= '0;
      end else if (run_go) begin
         if (wb_en && (mem_wreg_ff == dc_rs)) begin
            dec_a_ff <= wb_val;
         end else begin
            dec_a_ff <= rf_vld_ff[dc_rs] ? rf_mem_ff[dc_rs] : '0;
         end
         if (wb_en && (mem_wreg_ff == dc_rt)) begin
            dec_b_ff <= wb_val;
         end else begin
            dec_b_ff <= rf_vld_ff[dc_rt] ? rf_mem_ff[dc_rt] : '0;
         end
      end
   end

   // ---------------------------------------------------------------- data memory
   always_ff @(posedge clock) begin
      if (dm_we) begin
         data_mem_ff[dm_waddr] <= dm_wdata;
      end
      if (run_go && ms_load) begin
         mem_mdata_ff <= data_vld_ff[dm_raddr] ? data_mem_ff[dm_raddr] : '0;
      end
      if (accept) begin
         rd_data_ff <= (is_read && data_vld_ff[dm_raddr]) ? lo16(data_mem_ff[dm_raddr]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_vld_ff <= '0;
      end else if (dm_we) begin
         data_vld_ff[dm_waddr] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- pipeline latches
   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_ff     <= '0;
         dec_op_ff    <= '0;
         dec_rt_ff    <= '0;
         dec_rd_ff    <= '0;
         dec_funct_ff <= '0;
         dec_imm_ff   <= '0;
         ex_op_ff     <= '0;
         ex_alu_ff    <= '0;
         ex_b_ff      <= '0;
         ex_wreg_ff   <= '0;
         mem_op_ff    <= '0;
         mem_alu_ff   <= '0;
         mem_wreg_ff  <= '0;
      end else if (run_go) begin
         fetch_ff     <= req_instr_word;
         dec_op_ff    <= dc_op;
         dec_rt_ff    <= dc_rt;
         dec_rd_ff    <= dc_rd;
         dec_funct_ff <= dc_funct;
         dec_imm_ff   <= dc_imm;
         ex_op_ff     <= dec_op_ff;
         if (ex_upd) begin
            ex_alu_ff  <= ex_alu_in;
            ex_wreg_ff <= ex_wreg_in;
         end
         if (ex_b_upd) begin
            ex_b_ff <= dec_b_ff;
         end
         mem_op_ff    <= ex_op_ff;
         mem_alu_ff   <= ex_alu_ff;
         mem_wreg_ff  <= ex_wreg_ff;
      end
   end

   // ---------------------------------------------------------------- result register
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_reg_write_ff   <= run_go & wb_en;
         rsp_reg_index_ff   <= (run_go && wb_en) ? mem_wreg_ff : '0;
         rsp_reg_value_ff   <= (run_go && wb_en) ? lo16(wb_val) : '0;
         rsp_mem_write_ff   <= run_go & ms_store;
         rsp_mem_address_ff <= (run_go && (ms_load || ms_store)) ? ms_addr : '0;
         rsp_mem_value_ff   <= (run_go && ms_store) ? lo16(ex_b_ff) : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reg_write   = rsp_reg_write_ff;
   assign rsp_reg_index   = rsp_reg_index_ff;
   assign rsp_reg_value   = rsp_reg_value_ff;
   assign rsp_mem_write   = rsp_mem_write_ff;
   assign rsp_mem_address = rsp_mem_address_ff;
   assign rsp_mem_value   = rsp_mem_value_ff;
   assign rsp_read_data   = rd_data_ff;
   assign rsp_pc_value    = pc_ff;
   assign rsp_halted      = halt_ff;

   // ---------------------------------------------------------------- assertions
   `FSPC_ASSERT_NEXT(a_halt_sticks, clock, reset, halt_ff, halt_ff)
   `FSPC_ASSERT_NEXT(a_pc_advances, clock, reset, run_go, pc_ff == $past(pc_ff) + 9'd1)
   `FSPC_ASSERT_NEXT(a_pc_holds, clock, reset, !run_go, pc_ff == $past(pc_ff))
   `FSPC_ASSERT_NEXT(a_no_side_effects, clock, reset,
      accept && (req_command != fspc_pkg::CMD_RUN), !rsp_reg_write && !rsp_mem_write)
   `FSPC_ASSERT_NOW(a_halted_run_quiet, clock, reset,
      rsp_valid_ff && rsp_halted && rsp_reg_write, halt_ff)

endmodule

FILE: test/five_stage_pipeline_core_checker.sv
// Result checker for the five-stage pipeline core: predicts every response from the
// accepted requests and configuration writes, and compares it field by field.
// Depends on fspc_pkg only.
`timescale 1ns / 100ps

module five_stage_pipeline_core_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [fspc_pkg::PC_W-1:0]      csr_write_data,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_command,
   input  logic [15:0]                    req_instr_word,
   input  logic [fspc_pkg::ADDR_W-1:0]    req_address,
   input  logic [15:0]                    req_write_value,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_reg_write,
   input  logic [fspc_pkg::REG_IDX_W-1:0] rsp_reg_index,
   input  logic [15:0]                    rsp_reg_value,
   input  logic                           rsp_mem_write,
   input  logic [fspc_pkg::ADDR_W-1:0]    rsp_mem_address,
   input  logic [15:0]                    rsp_mem_value,
   input  logic [15:0]                    rsp_read_data,
   input  logic [fspc_pkg::PC_W-1:0]      rsp_pc_value,
   input  logic                           rsp_halted,
   output int                             mismatch_count,
   output int                             results_pending
);

   typedef struct packed {
      logic                           reg_write;
      logic [fspc_pkg::REG_IDX_W-1:0] reg_index;
      logic [15:0]                    reg_value;
      logic                           mem_write;
      logic [fspc_pkg::ADDR_W-1:0]    mem_address;
      logic [15:0]                    mem_value;
      logic [15:0]                    read_data;
      logic [fspc_pkg::PC_W-1:0]      pc_value;
      logic                           halted;
   } core_result_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [2:0]  rs, rt, rd, funct;
      logic [5:0]  imm;
      logic [15:0] a, b;
   } decoded_instr_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [15:0] alu, b;
      logic [2:0]  wreg;
   } executed_instr_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [15:0] mdata, alu;
      logic [2:0]  wreg;
   } memory_instr_type;

   logic [fspc_pkg::PC_W-1:0] prog_length;
   logic [fspc_pkg::PC_W-1:0] core_pc;
   logic                      core_halted;
   logic [15:0]               reg_file [fspc_pkg::REG_COUNT];
   logic [15:0]               data_mem [256];
   logic [15:0]               fetch_word;
   decoded_instr_type         decode_q;
   executed_instr_type        execute_q;
   memory_instr_type          memory_q;

   core_result_type predicted_results[$];

   initial begin
      mismatch_count = 0;
      results_pending = 0;
   end

   task automatic clear_core;
      prog_length = '0;
      core_pc = '0;
      core_halted = 1'b0;
      foreach (reg_file[i]) reg_file[i] = '0;
      foreach (data_mem[i]) data_mem[i] = '0;
      fetch_word = '0;
      decode_q = '0;
      execute_q = '0;
      memory_q = '0;
      predicted_results.delete();
   endtask

   // One advance of the pipeline, stages in order writeback, memory, execute, decode.
   task automatic advance_pipeline(inout core_result_type res);
      decoded_instr_type d;
      logic [15:0]       r;
      if (memory_q.op == fspc_pkg::OP_RTYPE || memory_q.op == fspc_pkg::OP_ADDI ||
          memory_q.op == fspc_pkg::OP_LW) begin
         res.reg_write = 1'b1;
         res.reg_index = memory_q.wreg;
         res.reg_value = (memory_q.op == fspc_pkg::OP_LW) ? memory_q.mdata : memory_q.alu;
         reg_file[memory_q.wreg] = res.reg_value;
      end

      if (execute_q.op == fspc_pkg::OP_LW) begin
         memory_q.mdata = data_mem[execute_q.alu[7:0]];
         res.mem_address = execute_q.alu[7:0];
      end else if (execute_q.op == fspc_pkg::OP_SW) begin
         data_mem[execute_q.alu[7:0]] = execute_q.b;
         res.mem_write = 1'b1;
         res.mem_address = execute_q.alu[7:0];
         res.mem_value = execute_q.b;
      end
      memory_q.alu = execute_q.alu;
      memory_q.wreg = execute_q.wreg;
      memory_q.op = execute_q.op;

      // other opcodes leave the stale ALU, store data and target in place
      case (decode_q.op)
         fspc_pkg::OP_RTYPE: begin
            case (decode_q.funct)
               fspc_pkg::FN_ADD: r = decode_q.a + decode_q.b;
               fspc_pkg::FN_SUB: r = decode_q.a - decode_q.b;
               fspc_pkg::FN_AND: r = decode_q.a & decode_q.b;
               fspc_pkg::FN_OR:  r = decode_q.a | decode_q.b;
               default:          r = '0;
            endcase
            execute_q.alu = r;
            execute_q.wreg = decode_q.rd;
         end
         fspc_pkg::OP_ADDI: begin
            execute_q.alu = decode_q.a + 16'(decode_q.imm);
            execute_q.wreg = decode_q.rt;
         end
         fspc_pkg::OP_LW, fspc_pkg::OP_SW: begin
            execute_q.alu = decode_q.a + 16'(decode_q.imm);
            execute_q.b = decode_q.b;
            execute_q.wreg = decode_q.rt;
         end
         default: ;
      endcase
      execute_q.op = decode_q.op;

      d = '0;
      d.op = fetch_word[15:12];
      if (d.op != fspc_pkg::OP_JUMP) begin
         d.rs = fetch_word[11:9];
         d.rt = fetch_word[8:6];
         if (d.op == fspc_pkg::OP_RTYPE) begin
            d.rd = fetch_word[5:3];
            d.funct = fetch_word[2:0];
         end else begin
            d.imm = fetch_word[5:0];
         end
      end
      d.a = reg_file[d.rs];
      d.b = reg_file[d.rt];
      decode_q = d;
   endtask

   task automatic predict_transaction(input logic [1:0] cmd, input logic [15:0] word,
                                      input logic [7:0] addr, input logic [15:0] value,
                                      output core_result_type res);
      res = '0;
      case (cmd)
         fspc_pkg::CMD_WRITE: data_mem[addr] = value;
         fspc_pkg::CMD_READ:  res.read_data = data_mem[addr];
         fspc_pkg::CMD_RUN: begin
            if (!core_halted) begin
               advance_pipeline(res);
               fetch_word = word;
               core_pc = core_pc + fspc_pkg::PC_W'(1);
               if (core_pc >= prog_length) core_halted = 1'b1;
            end
         end
         default: ;
      endcase
      res.pc_value = core_pc;
      res.halted = core_halted;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      core_result_type got, want;
      if (reset) begin
         clear_core();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_reg_write, rsp_reg_index, rsp_reg_value, rsp_mem_write,
                   rsp_mem_address, rsp_mem_value, rsp_read_data, rsp_pc_value, rsp_halted};
            if (predicted_results.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual 0x%0h",
                        $time, got);
               mismatch_count++;
            end else begin
               want = predicted_results.pop_front();
               check_field("reg_write", want.reg_write, got.reg_write);
               check_field("reg_index", want.reg_index, got.reg_index);
               check_field("reg_value", want.reg_value, got.reg_value);
               check_field("mem_write", want.mem_write, got.mem_write);
               check_field("mem_address", want.mem_address, got.mem_address);
               check_field("mem_value", want.mem_value, got.mem_value);
               check_field("read_data", want.read_data, got.read_data);
               check_field("pc_value", want.pc_value, got.pc_value);
               check_field("halted", want.halted, got.halted);
            end
         end
         if (req_valid && !req_stall) begin
            predict_transaction(req_command, req_instr_word, req_address, req_write_value,
                                want);
            predicted_results.push_back(want);
         end
         if (csr_write_enable) prog_length = csr_write_data;
      end
      results_pending = predicted_results.size();
   end

endmodule

FILE: test/five_stage_pipeline_core_tb.sv
// Testbench top for the five-stage pipeline core: clock, reset, request and stall
// stimulus, program length writes and the verdict.
// Depends on fspc_pkg, the core and five_stage_pipeline_core_checker.
`timescale 1ns / 100ps

module five_stage_pipeline_core_tb;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [3:0] OP_SPARE   = 4'd7;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_write_enable = 1'b0;
   logic [fspc_pkg::PC_W-1:0]      csr_write_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [1:0]                     req_command = fspc_pkg::CMD_WRITE;
   logic [15:0]                    req_instr_word = '0;
   logic [fspc_pkg::ADDR_W-1:0]    req_address = '0;
   logic [15:0]                    req_write_value = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_reg_write;
   logic [fspc_pkg::REG_IDX_W-1:0] rsp_reg_index;
   logic [15:0]                    rsp_reg_value;
   logic                           rsp_mem_write;
   logic [fspc_pkg::ADDR_W-1:0]    rsp_mem_address;
   logic [15:0]                    rsp_mem_value;
   logic [15:0]                    rsp_read_data;
   logic [fspc_pkg::PC_W-1:0]      rsp_pc_value;
   logic                           rsp_halted;

   int mismatch_count;
   int results_pending;
   int run_count = 0;
   bit steady = 1'b0;

   five_stage_pipeline_core uut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_instr_word(req_instr_word), .req_address(req_address),
      .req_write_value(req_write_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_reg_write(rsp_reg_write),
      .rsp_reg_index(rsp_reg_index), .rsp_reg_value(rsp_reg_value),
      .rsp_mem_write(rsp_mem_write), .rsp_mem_address(rsp_mem_address),
      .rsp_mem_value(rsp_mem_value), .rsp_read_data(rsp_read_data),
      .rsp_pc_value(rsp_pc_value), .rsp_halted(rsp_halted)
   );

   five_stage_pipeline_core_checker result_check (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_instr_word(req_instr_word), .req_address(req_address),
      .req_write_value(req_write_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_reg_write(rsp_reg_write),
      .rsp_reg_index(rsp_reg_index), .rsp_reg_value(rsp_reg_value),
      .rsp_mem_write(rsp_mem_write), .rsp_mem_address(rsp_mem_address),
      .rsp_mem_value(rsp_mem_value), .rsp_read_data(rsp_read_data),
      .rsp_pc_value(rsp_pc_value), .rsp_halted(rsp_halted),
      .mismatch_count(mismatch_count), .results_pending(results_pending)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 34);
   end

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [15:0] r_word(input logic [2:0] rs, rt, rd, fn);
      return {fspc_pkg::OP_RTYPE, rs, rt, rd, fn};
   endfunction

   function automatic logic [15:0] i_word(input logic [3:0] op, input logic [2:0] rs, rt,
                                          input logic [5:0] imm);
      return {op, rs, rt, imm};
   endfunction

   // Mostly the supported instructions, now and then any word at all.
   function automatic logic [15:0] random_instruction();
      int unsigned pick;
      logic [2:0]  fn;
      pick = $urandom_range(99);
      fn = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
      if ($urandom_range(9) != 0) begin
         case (fn)
            3'd0: fn = fspc_pkg::FN_ADD;
            3'd1: fn = fspc_pkg::FN_SUB;
            3'd2: fn = fspc_pkg::FN_AND;
            default: fn = fspc_pkg::FN_OR;
         endcase
      end
      if (pick < 35)
         return r_word(3'($urandom), 3'($urandom), 3'($urandom), fn);
      else if (pick < 55)
         return i_word(fspc_pkg::OP_ADDI, 3'($urandom), 3'($urandom), 6'($urandom));
      else if (pick < 70)
         return i_word(fspc_pkg::OP_LW, 3'($urandom), 3'($urandom), 6'($urandom));
      else if (pick < 85)
         return i_word(fspc_pkg::OP_SW, 3'($urandom), 3'($urandom), 6'($urandom));
      return 16'($urandom);
   endfunction

   task automatic send_transaction(input logic [1:0] cmd, input logic [15:0] word,
                                   input logic [7:0] addr, input logic [15:0] value);
      while (!steady && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_instr_word <= word;
      req_address <= addr;
      req_write_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == fspc_pkg::CMD_RUN) run_count++;
      @(negedge clock);
   endtask

   task automatic random_transaction(input bit allow_run);
      int unsigned pick;
      logic [7:0]  addr;
      pick = $urandom_range(99);
      addr = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      if (allow_run && pick < 30)
         send_transaction(fspc_pkg::CMD_RUN, random_instruction(), addr, 16'($urandom));
      else if (pick < 60)
         send_transaction(fspc_pkg::CMD_WRITE, 16'($urandom), addr, 16'($urandom));
      else if (pick < 95)
         send_transaction(fspc_pkg::CMD_READ, 16'($urandom), addr, 16'($urandom));
      else
         send_transaction(CMD_UNUSED, 16'($urandom), addr, 16'($urandom));
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_pending != 0) @(negedge clock);
   endtask

   task automatic write_program_length(input logic [fspc_pkg::PC_W-1:0] len);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= len;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // data memory only while the program length is zero
      write_program_length(9'd0);
      send_transaction(fspc_pkg::CMD_WRITE, 16'h0000, 8'd0, 16'hFFFF);
      send_transaction(fspc_pkg::CMD_WRITE, 16'h0000, 8'd255, 16'h8001);
      send_transaction(fspc_pkg::CMD_READ, 16'h0000, 8'd255, 16'h0000);
      send_transaction(fspc_pkg::CMD_READ, 16'h0000, 8'd0, 16'h0000);
      send_transaction(fspc_pkg::CMD_READ, 16'h0000, 8'd128, 16'h0000);
      send_transaction(CMD_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF);

      // a short program: the empty latches drain first as writes of zero to r0
      write_program_length(9'd256);
      send_transaction(fspc_pkg::CMD_RUN, i_word(fspc_pkg::OP_ADDI, 3'd0, 3'd1, 6'd63),
                       8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_RUN, i_word(fspc_pkg::OP_ADDI, 3'd0, 3'd2, 6'd1),
                       8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_RUN, i_word(fspc_pkg::OP_ADDI, 3'd7, 3'd7, 6'd0),
                       8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_RUN, r_word(3'd0, 3'd0, 3'd0, fspc_pkg::FN_ADD),
                       8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_RUN, r_word(3'd1, 3'd2, 3'd3, fspc_pkg::FN_ADD),
                       8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_RUN, r_word(3'd2, 3'd1, 3'd4, fspc_pkg::FN_SUB),
                       8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_RUN, r_word(3'd1, 3'd2, 3'd5, fspc_pkg::FN_AND),
                       8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_RUN, r_word(3'd1, 3'd2, 3'd6, fspc_pkg::FN_OR),
                       8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_RUN, r_word(3'd1, 3'd2, 3'd0, 3'd7), 8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_RUN, i_word(fspc_pkg::OP_SW, 3'd2, 3'd1, 6'd63),
                       8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_RUN, i_word(fspc_pkg::OP_LW, 3'd0, 3'd7, 6'd0),
                       8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_RUN, i_word(fspc_pkg::OP_JUMP, 3'd7, 3'd7, 6'd63),
                       8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_RUN, i_word(OP_SPARE, 3'd7, 3'd7, 6'd63), 8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_RUN, i_word(fspc_pkg::OP_SW, 3'd7, 3'd7, 6'd63),
                       8'd0, 16'd0);
      repeat (3) send_transaction(fspc_pkg::CMD_RUN,
                                  r_word(3'd0, 3'd0, 3'd0, fspc_pkg::FN_ADD), 8'd0, 16'd0);
      send_transaction(fspc_pkg::CMD_READ, 16'h0000, 8'd64, 16'h0000);

      // keep the core running: stop issuing cycles well before the length
      for (int i = 0; i < 700; i++) begin
         steady = (i >= 250 && i < 450);
         random_transaction(run_count < 200);
      end
      steady = 1'b0;

      // lower the length so the core reaches its halt
      write_program_length(9'd230);
      for (int i = 0; i < 900; i++) random_transaction(1'b1);

      // raising the length again must not leave the halt
      write_program_length(9'd256);
      for (int i = 0; i < 400; i++) random_transaction(1'b1);

      drain_results();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/fspc_pkg.sv
design/five_stage_pipeline_core.sv
test/five_stage_pipeline_core_checker.sv
test/five_stage_pipeline_core_tb.sv
